// ----- rtl/avt_pkg.sv -----
package avt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int RES_W     = SUM_W + 1;
	localparam int CFG_W     = 64;
	localparam int IDX_W     = 3;
	localparam int NUM_MREGS = 6;

	// register indexes on the config port
	localparam logic [IDX_W-1:0] CFG_ROW0_COLS01   = 3'd0;
	localparam logic [IDX_W-1:0] CFG_ROW0_COLS23   = 3'd1;
	localparam logic [IDX_W-1:0] CFG_ROW1_COLS01   = 3'd2;
	localparam logic [IDX_W-1:0] CFG_ROW1_COLS23   = 3'd3;
	localparam logic [IDX_W-1:0] CFG_ROW2_COLS01   = 3'd4;
	localparam logic [IDX_W-1:0] CFG_ROW2_COLS23   = 3'd5;
	localparam logic [IDX_W-1:0] CFG_ADD_TRANSLATE = 3'd6;

	// reset matrix is identity, zero translation
	localparam logic [CFG_W-1:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
	localparam logic [CFG_W-1:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;

	typedef struct packed {
		logic signed [DATA_W-1:0] in_x;
		logic signed [DATA_W-1:0] in_y;
		logic signed [DATA_W-1:0] in_z;
		logic                     last_in_batch;
	} vec_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
		logic                     saturated;
		logic                     last_out;
	} xf_t;

endpackage

// ----- rtl/affine_vertex_transform.sv -----
// Transforms one 3-D Q16.16 vector per beat by a 3x4 affine matrix held in config
// registers; each beat is registered in a multiply stage, a sum stage, then a
// shift/translate/clamp stage. With no stall on the result side a new vector is taken
// every cycle. Stalls ripple back stage by stage, so bubbles in the pipe are filled
// before the source is stalled. Config writes are always ready and take effect at once;
// write them only while the pipe is empty.
module affine_vertex_transform (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vec_valid,
	output logic                          vec_stall,
	input  avt_pkg::vec_t                 vec_data,
	output logic                          xf_valid,
	input  logic                          xf_stall,
	output avt_pkg::xf_t                  xf_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [avt_pkg::IDX_W-1:0]     cfg_index,
	input  logic [avt_pkg::CFG_W-1:0]     cfg_data
);

	localparam logic signed [avt_pkg::RES_W-1:0] RES_MAX =
		avt_pkg::RES_W'({1'b0, {(avt_pkg::DATA_W-1){1'b1}}});
	localparam logic signed [avt_pkg::RES_W-1:0] RES_MIN = -RES_MAX - 1;

	logic [avt_pkg::CFG_W-1:0]          mat_q [avt_pkg::NUM_MREGS];
	logic                               add_tr_q;
	logic signed [avt_pkg::DATA_W-1:0]  m_elem [3][4];

	logic                               valid_s1, valid_s2, valid_s3;
	logic                               adv1, adv2, adv3;
	logic signed [avt_pkg::PROD_W-1:0]  prod_s1 [3][3];
	logic                               last_s1;
	logic signed [avt_pkg::SUM_W-1:0]   sum_s2 [3];
	logic                               last_s2;

	logic signed [avt_pkg::SUM_W-1:0]   shifted [3];
	logic signed [avt_pkg::RES_W-1:0]   res [3];
	logic signed [avt_pkg::DATA_W-1:0]  clamped [3];
	logic [2:0]                         clamp_hit;
	avt_pkg::xf_t                       xf_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= avt_pkg::RST_ROW0_COLS01;
			mat_q[1] <= avt_pkg::RST_ROW0_COLS23;
			mat_q[2] <= avt_pkg::RST_ROW1_COLS01;
			mat_q[3] <= avt_pkg::RST_ROW1_COLS23;
			mat_q[4] <= avt_pkg::RST_ROW2_COLS01;
			mat_q[5] <= avt_pkg::RST_ROW2_COLS23;
			add_tr_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				avt_pkg::CFG_ROW0_COLS01:   mat_q[0] <= cfg_data;
				avt_pkg::CFG_ROW0_COLS23:   mat_q[1] <= cfg_data;
				avt_pkg::CFG_ROW1_COLS01:   mat_q[2] <= cfg_data;
				avt_pkg::CFG_ROW1_COLS23:   mat_q[3] <= cfg_data;
				avt_pkg::CFG_ROW2_COLS01:   mat_q[4] <= cfg_data;
				avt_pkg::CFG_ROW2_COLS23:   mat_q[5] <= cfg_data;
				avt_pkg::CFG_ADD_TRANSLATE: add_tr_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			m_elem[r][0] = mat_q[2*r][avt_pkg::DATA_W-1:0];
			m_elem[r][1] = mat_q[2*r][avt_pkg::CFG_W-1:avt_pkg::DATA_W];
			m_elem[r][2] = mat_q[2*r+1][avt_pkg::DATA_W-1:0];
			m_elem[r][3] = mat_q[2*r+1][avt_pkg::CFG_W-1:avt_pkg::DATA_W];
		end
	end

	// a stage moves when it is empty or the one after it moves
	assign adv3      = !valid_s3 || !xf_stall;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign vec_stall = !adv1;

	// stage 1: nine products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= vec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && vec_valid) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= m_elem[r][0] * vec_data.in_x;
				prod_s1[r][1] <= m_elem[r][1] * vec_data.in_y;
				prod_s1[r][2] <= m_elem[r][2] * vec_data.in_z;
			end
			last_s1 <= vec_data.last_in_batch;
		end
	end

	// stage 2: exact row sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= avt_pkg::SUM_W'(prod_s1[r][0])
					+ avt_pkg::SUM_W'(prod_s1[r][1])
					+ avt_pkg::SUM_W'(prod_s1[r][2]);
			end
			last_s2 <= last_s1;
		end
	end

	// stage 3: floor shift, translation, clamp
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			shifted[r] = sum_s2[r] >>> avt_pkg::FRAC_BITS;
			res[r]     = avt_pkg::RES_W'(shifted[r])
				+ (add_tr_q ? avt_pkg::RES_W'(m_elem[r][3]) : '0);
			if (res[r] > RES_MAX) begin
				clamped[r]   = RES_MAX[avt_pkg::DATA_W-1:0];
				clamp_hit[r] = 1'b1;
			end else if (res[r] < RES_MIN) begin
				clamped[r]   = RES_MIN[avt_pkg::DATA_W-1:0];
				clamp_hit[r] = 1'b1;
			end else begin
				clamped[r]   = res[r][avt_pkg::DATA_W-1:0];
				clamp_hit[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			xf_s3.out_x     <= clamped[0];
			xf_s3.out_y     <= clamped[1];
			xf_s3.out_z     <= clamped[2];
			xf_s3.saturated <= |clamp_hit;
			xf_s3.last_out  <= last_s2;
		end
	end

	assign xf_valid = valid_s3;
	assign xf_data  = xf_s3;

	// source is only stalled when every stage holds a beat
	assert property (@(posedge clk) disable iff (!arst_n)
		vec_stall |-> (valid_s1 && valid_s2 && valid_s3 && xf_stall))
		else $error("input stalled with a bubble in the pipe");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !valid_s3) |=> valid_s3)
		else $error("stage 2 beat did not move into empty stage 3");

	assert property (@(posedge clk) disable iff (!arst_n)
		(xf_valid && xf_data.saturated) |->
			(xf_data.out_x == RES_MAX[avt_pkg::DATA_W-1:0]
			|| xf_data.out_x == RES_MIN[avt_pkg::DATA_W-1:0]
			|| xf_data.out_y == RES_MAX[avt_pkg::DATA_W-1:0]
			|| xf_data.out_y == RES_MIN[avt_pkg::DATA_W-1:0]
			|| xf_data.out_z == RES_MAX[avt_pkg::DATA_W-1:0]
			|| xf_data.out_z == RES_MIN[avt_pkg::DATA_W-1:0]))
		else $error("saturated flag without a clamped component");

endmodule

// ----- tb/tb_affine_vertex_transform.sv -----
`timescale 1ns / 1ps

module tb_affine_vertex_transform;
	import avt_pkg::*;

	localparam int                 CYCLE_LIMIT = 400000;
	localparam logic [IDX_W-1:0]   CFG_NO_REG  = 3'd7;
	localparam logic [DATA_W-1:0]  Q_MAX       = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0]  Q_MIN       = 32'h8000_0000;
	localparam logic [DATA_W-1:0]  Q_ONE       = 32'h0001_0000;
	localparam logic [IDX_W-1:0]   MREG_IDX [NUM_MREGS] = '{CFG_ROW0_COLS01, CFG_ROW0_COLS23,
		CFG_ROW1_COLS01, CFG_ROW1_COLS23, CFG_ROW2_COLS01, CFG_ROW2_COLS23};

	class xf_scoreboard;
		xf_t              expected_q[$];
		int               errors;
		logic [CFG_W-1:0] mreg [NUM_MREGS];
		bit               add_trans;

		function new();
			errors    = 0;
			mreg      = '{RST_ROW0_COLS01, RST_ROW0_COLS23, RST_ROW1_COLS01,
				RST_ROW1_COLS23, RST_ROW2_COLS01, RST_ROW2_COLS23};
			add_trans = 1'b1;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == CFG_ADD_TRANSLATE) begin
				add_trans = val[0];
			end else if (idx < NUM_MREGS) begin
				mreg[idx] = val;
			end
		endfunction

		function logic signed [DATA_W-1:0] elem(int row, int col);
			logic [CFG_W-1:0] w;
			w = mreg[row * 2 + col / 2];
			return (col % 2) ? w[63:32] : w[31:0];
		endfunction

		// exact dot product, floor shift, optional translation, then clamp
		function xf_t transform(vec_t v);
			logic signed [DATA_W-1:0] vin [3];
			logic signed [DATA_W-1:0] comp [3];
			logic signed [67:0]       a;
			logic signed [67:0]       b;
			logic signed [67:0]       acc;
			logic signed [68:0]       res;
			xf_t                      r;
			bit                       sat;
			vin = '{v.in_x, v.in_y, v.in_z};
			sat = 1'b0;
			for (int row = 0; row < 3; row++) begin
				acc = '0;
				for (int col = 0; col < 3; col++) begin
					a   = elem(row, col);
					b   = vin[col];
					acc = acc + a * b;
				end
				res = acc >>> FRAC_BITS;
				if (add_trans)
					res = res + elem(row, 3);
				if (res > 69'sd2147483647) begin
					res = 69'sd2147483647;
					sat = 1'b1;
				end else if (res < -69'sd2147483648) begin
					res = -69'sd2147483648;
					sat = 1'b1;
				end
				comp[row] = res[DATA_W-1:0];
			end
			r.out_x     = comp[0];
			r.out_y     = comp[1];
			r.out_z     = comp[2];
			r.saturated = sat;
			r.last_out  = v.last_in_batch;
			return r;
		endfunction

		function void note_vector(vec_t v);
			expected_q.push_back(transform(v));
		endfunction

		function void check_result(xf_t got);
			xf_t exp_xf;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: x %0d y %0d z %0d",
					got.out_x, got.out_y, got.out_z);
				errors++;
				return;
			end
			exp_xf = expected_q.pop_front();
			if (got.out_x !== exp_xf.out_x) begin
				$error("out_x expected %0d got %0d", exp_xf.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== exp_xf.out_y) begin
				$error("out_y expected %0d got %0d", exp_xf.out_y, got.out_y);
				errors++;
			end
			if (got.out_z !== exp_xf.out_z) begin
				$error("out_z expected %0d got %0d", exp_xf.out_z, got.out_z);
				errors++;
			end
			if (got.saturated !== exp_xf.saturated) begin
				$error("saturated expected %0b got %0b", exp_xf.saturated, got.saturated);
				errors++;
			end
			if (got.last_out !== exp_xf.last_out) begin
				$error("last_out expected %0b got %0b", exp_xf.last_out, got.last_out);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             vec_valid;
	logic             vec_stall;
	vec_t             vec_data;
	logic             xf_valid;
	logic             xf_stall;
	xf_t              xf_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	xf_scoreboard sb;
	int           cycles;

	affine_vertex_transform u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec_valid (vec_valid),
		.vec_stall (vec_stall),
		.vec_data  (vec_data),
		.xf_valid  (xf_valid),
		.xf_stall  (xf_stall),
		.xf_data   (xf_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && xf_valid && !xf_stall)
			sb.check_result(xf_data);
	end

	function automatic vec_t mk_vec(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
		logic [DATA_W-1:0] z, logic last);
		vec_t v;
		v.in_x          = x;
		v.in_y          = y;
		v.in_z          = z;
		v.last_in_batch = last;
		return v;
	endfunction

	function automatic logic [DATA_W-1:0] rand_comp();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5)
			return $urandom;
		if (k < 8)
			return $urandom_range(0, 2 ** 21) - 2 ** 20;
		case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return 32'd1;
			4: return '1;
			default: return Q_ONE;
		endcase
	endfunction

	function automatic vec_t rand_vec();
		return mk_vec(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 7) == 0);
	endfunction

	function automatic logic [DATA_W-1:0] rand_elem(int mode);
		case (mode)
			0: return $urandom;
			1: return Q_MAX;
			2: return Q_MIN;
			3: return '0;
			4: return $urandom_range(0, 2 ** 18) - 2 ** 17;
			default: begin
				case ($urandom_range(0, 4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return Q_ONE;
					3: return -Q_ONE;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic send_vec(vec_t v, int gap);
		if (gap > 0) begin
			vec_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vec_valid <= 1'b1;
		vec_data  <= v;
		do @(posedge clk); while (vec_stall);
		sb.note_vector(v);
	endtask

	task automatic write_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	task automatic load_config(logic [CFG_W-1:0] regs [NUM_MREGS], logic [CFG_W-1:0] trans,
		bit poke_unused);
		for (int i = 0; i < NUM_MREGS; i++)
			write_cfg(MREG_IDX[i], regs[i]);
		write_cfg(CFG_ADD_TRANSLATE, trans);
		// no register behind this index, write must be dropped
		if (poke_unused)
			write_cfg(CFG_NO_REG, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		vec_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] regs [NUM_MREGS];
		logic [CFG_W-1:0] trans;
		bit               quiet;
		int               mode;
		sb        = new();
		cycles    = 0;
		clk       = 1'b0;
		arst_n    = 1'b0;
		vec_valid = 1'b0;
		vec_data  = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset
		send_vec(mk_vec('0, '0, '0, 1'b0), 0);
		send_vec(mk_vec(32'd1, '1, Q_MAX, 1'b1), 0);
		send_vec(mk_vec(Q_MIN, Q_MAX, '1, 1'b0), 2);
		send_vec(mk_vec(Q_MAX, Q_MAX, Q_MAX, 1'b0), 0);
		send_vec(mk_vec(Q_MIN, Q_MIN, Q_MIN, 1'b1), 0);
		send_vec(mk_vec(Q_ONE, -Q_ONE, 32'h7FFF_0000, 1'b0), 1);
		send_vec(mk_vec('1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1), 0);
		drain();

		// row 0 tiny elements shows floor on negatives, rows 1 and 2 overflow
		regs = '{{32'd1, 32'd1}, {32'd0, 32'd1}, {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX},
			{Q_MIN, Q_MIN}, {Q_MIN, Q_MIN}};
		load_config(regs, 64'd1, 1'b1);
		send_vec(mk_vec('1, '0, '0, 1'b0), 0);
		send_vec(mk_vec('1, '1, '1, 1'b0), 0);
		send_vec(mk_vec(32'd1, 32'd1, 32'd1, 1'b1), 3);
		send_vec(mk_vec(Q_MAX, Q_MAX, Q_MAX, 1'b0), 0);
		send_vec(mk_vec(Q_MIN, Q_MIN, Q_MIN, 1'b0), 0);
		send_vec(mk_vec(Q_MAX, Q_MIN, '0, 1'b1), 0);
		send_vec(mk_vec('0, '0, '0, 1'b0), 0);
		send_vec(mk_vec(32'd1, '0, '0, 1'b1), 0);
		drain();

		// translation off, upper value bits set to check only bit 0 counts
		load_config(regs, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
		send_vec(mk_vec('0, '0, '0, 1'b0), 0);
		send_vec(mk_vec('1, '1, '1, 1'b1), 0);
		send_vec(mk_vec(Q_MAX, Q_MAX, Q_MAX, 1'b0), 1);
		send_vec(mk_vec(Q_MIN, Q_MAX, Q_MIN, 1'b0), 0);
		send_vec(mk_vec(32'd1, '0, '1, 1'b1), 0);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			mode = ph % 6;
			for (int i = 0; i < NUM_MREGS; i++)
				regs[i] = {rand_elem(mode), rand_elem(mode)};
			trans    = {$urandom, $urandom};
			trans[0] = ph[0];
			load_config(regs, trans, ph % 3 == 0);
			for (int n = 0; n < 95; n++) begin
				if (n % 20 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				send_vec(rand_vec(), quiet ? 0 : pick_gap());
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side back-pressure: free stretches, scattered stalls, some long holds
	initial begin
		int mode;
		xf_stall = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			mode = $urandom_range(0, 9);
			if (mode < 3) begin
				xf_stall <= 1'b0;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else if (mode < 9) begin
				repeat ($urandom_range(1, 20)) begin
					xf_stall <= ($urandom_range(0, 99) < 30);
					@(posedge clk);
				end
			end else begin
				xf_stall <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

endmodule
